// ----- hw/rtl/tce_pkg.sv -----
// shared types and constants of the tiny cpu execute unit
// opcode and condition codes, decoded control word, result word
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

    localparam int DATA_W    = 8;
    localparam int FLAGS_W   = 4;
    localparam int SIGN_BIT  = 7;
    localparam int FLAG_V    = 3;
    localparam int FLAG_N    = 2;
    localparam int FLAG_Z    = 1;
    localparam int FLAG_C    = 0;
    localparam int REG_FLD_W = 2;

    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_CP     = 4'd3,
        OP_MOV    = 4'd4,
        OP_STOP   = 4'd5,
        OP_SUBI   = 4'd6,
        OP_CPI    = 4'd7,
        OP_LDI    = 4'd8,
        OP_JMP    = 4'd9,
        OP_BRANCH = 4'd10
    } opcode_t;

    typedef enum logic [1:0] {
        COND_EQ = 2'd0,
        COND_LO = 2'd1,
        COND_VS = 2'd2,
        COND_LT = 2'd3
    } cond_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_ALU,
        K_MOV,
        K_STOP,
        K_LDI,
        K_JMP,
        K_BRANCH
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  sub;
        logic  use_imm;
        logic  wr_dest;
        cond_t cond;
    } op_ctrl_t;

    typedef struct packed {
        logic                halted;
        logic [DATA_W-1:0]   dest_value;
        logic                taken;
        logic [DATA_W-1:0]   pc_value;
        logic [FLAGS_W-1:0]  flags;
        logic [DATA_W-1:0]   acc_value;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tce_front.sv -----
// front end: classifies an incoming instruction into a control word
// and folds register fields into the register file range; uses tce_pkg
`timescale 1ns / 1ps
`default_nettype none

module tce_front #(
    parameter int NUM_REGS = 4,
    parameter int IDX_W    = 2
) (
    input  wire logic [3:0]                    opcode,
    input  wire logic [tce_pkg::REG_FLD_W-1:0] dest_reg,
    input  wire logic [tce_pkg::REG_FLD_W-1:0] src_reg,
    input  wire logic [1:0]                    branch_cond,
    output tce_pkg::op_ctrl_t                  ctrl,
    output logic [IDX_W-1:0]                   ra,
    output logic [IDX_W-1:0]                   rb
);
    import tce_pkg::*;

    // field is below 4, so one conditional subtract gives the modulo
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [REG_FLD_W-1:0] fld);
        logic [4:0] ext;
        logic [4:0] red;
        begin
            ext = {3'b000, fld};
            red = (ext >= 5'(NUM_REGS)) ? ext - 5'(NUM_REGS) : ext;
            wrap_idx = red[IDX_W-1:0];
        end
    endfunction

    assign ra = wrap_idx(dest_reg);
    assign rb = wrap_idx(src_reg);

    always_comb
    begin
        ctrl.kind    = K_NOP;
        ctrl.sub     = 1'b0;
        ctrl.use_imm = 1'b0;
        ctrl.wr_dest = 1'b0;
        ctrl.cond    = cond_t'(branch_cond);
        case (opcode_t'(opcode))
            OP_ADD:
            begin
                ctrl.kind    = K_ALU;
                ctrl.wr_dest = 1'b1;
            end
            OP_SUB:
            begin
                ctrl.kind    = K_ALU;
                ctrl.sub     = 1'b1;
                ctrl.wr_dest = 1'b1;
            end
            OP_CP:
            begin
                ctrl.kind = K_ALU;
                ctrl.sub  = 1'b1;
            end
            OP_MOV:
            begin
                ctrl.kind    = K_MOV;
                ctrl.wr_dest = 1'b1;
            end
            OP_STOP:   ctrl.kind = K_STOP;
            OP_SUBI:
            begin
                ctrl.kind    = K_ALU;
                ctrl.sub     = 1'b1;
                ctrl.use_imm = 1'b1;
                ctrl.wr_dest = 1'b1;
            end
            OP_CPI:
            begin
                ctrl.kind    = K_ALU;
                ctrl.sub     = 1'b1;
                ctrl.use_imm = 1'b1;
            end
            OP_LDI:
            begin
                ctrl.kind    = K_LDI;
                ctrl.wr_dest = 1'b1;
            end
            OP_JMP:    ctrl.kind = K_JMP;
            OP_BRANCH: ctrl.kind = K_BRANCH;
            default:   ctrl.kind = K_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tce_queue.sv -----
// two-entry queue between front and back end
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module tce_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  can_push,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data,
    output logic [1:0]            level
);
    localparam int DEPTH = 2;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign can_push  = (count_reg != 2'(DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign level     = count_reg;
    assign do_push   = push && can_push;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tce_back.sv -----
// back end: register file read stage, execute stage and result register
// holds the architectural state; uses tce_pkg
`timescale 1ns / 1ps
`default_nettype none

module tce_back #(
    parameter int NUM_REGS = 4,
    parameter int IDX_W    = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  tce_pkg::op_ctrl_t                 in_ctrl,
    input  wire logic [IDX_W-1:0]             in_ra,
    input  wire logic [IDX_W-1:0]             in_rb,
    input  wire logic [tce_pkg::DATA_W-1:0]   in_imm,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output tce_pkg::result_t                  out_res,
    output logic                              stopped
);
    import tce_pkg::*;

    // register file and per-entry valid bits (unwritten entries read zero)
    logic [DATA_W-1:0]   rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_vld_reg;

    // execute stage
    logic                e_valid_reg;
    op_ctrl_t            e_ctrl_reg;
    logic [IDX_W-1:0]    e_ra_reg;
    logic [DATA_W-1:0]   e_imm_reg;
    logic [DATA_W-1:0]   rd_a_reg;
    logic [DATA_W-1:0]   rd_b_reg;

    // architectural state
    logic [DATA_W-1:0]   acc_reg;
    logic [DATA_W-1:0]   acc_next;
    logic [FLAGS_W-1:0]  flags_reg;
    logic [FLAGS_W-1:0]  flags_next;
    logic [DATA_W-1:0]   pc_reg;
    logic [DATA_W-1:0]   pc_next;
    logic                stopped_reg;
    logic                stopped_next;

    // result register
    logic                out_valid_reg;
    result_t             out_res_reg;
    result_t             res_next;

    logic                out_free;
    logic                e_fire;
    logic                load;
    logic                wr_en;
    logic [DATA_W-1:0]   wr_data;
    logic                taken;
    logic                cond_ok;
    logic [DATA_W-1:0]   opnd_b;
    logic [DATA_W-1:0]   bb;
    logic [DATA_W-1:0]   alu_r;
    logic [FLAGS_W-1:0]  alu_f;
    logic                fwd_a;
    logic                fwd_b;

    assign out_free  = !out_valid_reg || out_ready;
    assign e_fire    = e_valid_reg && out_free;
    assign in_ready  = !e_valid_reg || out_free;
    assign load      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign stopped   = stopped_reg;

    // adder with flags; subtract adds the negated operand
    always_comb
    begin
        opnd_b = e_ctrl_reg.use_imm ? e_imm_reg : rd_b_reg;
        bb     = e_ctrl_reg.sub ? (~opnd_b + DATA_W'(1)) : opnd_b;
        alu_r  = rd_a_reg + bb;
        alu_f[FLAG_V] = (rd_a_reg[SIGN_BIT] == bb[SIGN_BIT])
                        && (rd_a_reg[SIGN_BIT] != alu_r[SIGN_BIT]);
        alu_f[FLAG_N] = alu_r[SIGN_BIT];
        alu_f[FLAG_Z] = (alu_r == '0);
        alu_f[FLAG_C] = e_ctrl_reg.sub ? (alu_r >= rd_a_reg) : (alu_r < rd_a_reg);
    end

    always_comb
    begin
        case (e_ctrl_reg.cond)
            COND_EQ: cond_ok = flags_reg[FLAG_Z];
            COND_LO: cond_ok = flags_reg[FLAG_C];
            COND_VS: cond_ok = flags_reg[FLAG_V];
            COND_LT: cond_ok = flags_reg[FLAG_V] ^ flags_reg[FLAG_N];
            default: cond_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        acc_next     = acc_reg;
        flags_next   = flags_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        taken        = 1'b0;
        wr_en        = 1'b0;
        wr_data      = rd_a_reg;
        if (e_fire && !stopped_reg)
        begin
            case (e_ctrl_reg.kind)
                K_ALU:
                begin
                    acc_next   = alu_r;
                    flags_next = alu_f;
                    wr_en      = e_ctrl_reg.wr_dest;
                    wr_data    = alu_r;
                end
                K_MOV:
                begin
                    acc_next = rd_b_reg;
                    wr_en    = 1'b1;
                    wr_data  = rd_b_reg;
                end
                K_STOP:   stopped_next = 1'b1;
                K_LDI:
                begin
                    acc_next = e_imm_reg;
                    wr_en    = 1'b1;
                    wr_data  = e_imm_reg;
                end
                K_JMP:
                begin
                    acc_next = e_imm_reg;
                    pc_next  = e_imm_reg;
                    taken    = 1'b1;
                end
                K_BRANCH:
                begin
                    if (cond_ok)
                    begin
                        acc_next = e_imm_reg;
                        pc_next  = e_imm_reg;
                        taken    = 1'b1;
                    end
                end
                default:  taken = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        res_next.acc_value  = acc_next;
        res_next.flags      = flags_next;
        res_next.pc_value   = pc_next;
        res_next.taken      = taken;
        // compares leave register a as it was
        res_next.dest_value = wr_en ? wr_data : rd_a_reg;
        res_next.halted     = stopped_next;
    end

    // a write retiring this cycle is forwarded into the read stage
    assign fwd_a = wr_en && (e_ra_reg == in_ra);
    assign fwd_b = wr_en && (e_ra_reg == in_rb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            flags_reg     <= '0;
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            rf_vld_reg    <= '0;
        end
        else
        begin
            if (load)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_fire)
            begin
                e_valid_reg <= 1'b0;
            end
            if (e_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            acc_reg     <= acc_next;
            flags_reg   <= flags_next;
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
            if (wr_en)
            begin
                rf_vld_reg[e_ra_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[e_ra_reg] <= wr_data;
        end
        if (load)
        begin
            e_ctrl_reg <= in_ctrl;
            e_ra_reg   <= in_ra;
            e_imm_reg  <= in_imm;
            rd_a_reg   <= fwd_a ? wr_data
                          : (rf_vld_reg[in_ra] ? rf_mem[in_ra] : '0);
            rd_b_reg   <= fwd_b ? wr_data
                          : (rf_vld_reg[in_rb] ? rf_mem[in_rb] : '0);
        end
        if (e_fire)
        begin
            out_res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tiny_cpu_execute_unit.sv -----
// top level of the tiny cpu execute unit: front end, queue, back end
// depends on tce_pkg, tce_front, tce_queue, tce_back
//
//   channel  | direction | contents
//   ---------+-----------+------------------------------------------------
//   s_axis   | in        | one decoded instruction per transfer
//   m_axis   | out       | one result per instruction (state after it)
//
// one instruction per cycle sustained while m_axis is ready; an input
// transfer reaches result valid through the queue slot, then register
// read into the execute stage, then execute into the result register
// the execute stage retires one instruction a cycle, bounded by the single
// register file write port and the flag/pc/accumulator update loop
// reset clears the register file valid bits, accumulator, flags, pc, the
// stop flag, the queue and all valid bits; no clearing pass is needed
// a stall on m_axis backs up into execute, then the two-entry queue
`timescale 1ns / 1ps
`default_nettype none

module tiny_cpu_execute_unit #(
    parameter int NUM_REGS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode[3:0], dest_reg[5:4], src_reg[7:6], immediate[15:8],
    // branch_cond[17:16], zero[23:18]
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // acc_value[7:0], flags[11:8], pc_value[19:12], branch_taken[20],
    // dest_value[28:21], halted[29], zero[31:30]
    output logic [31:0]      m_axis_tdata
);
    import tce_pkg::*;

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam int CTRL_W = $bits(op_ctrl_t);
    localparam int Q_W = CTRL_W + 2 * IDX_W + DATA_W;

    // front end outputs
    op_ctrl_t          f_ctrl;
    logic [IDX_W-1:0]  f_ra;
    logic [IDX_W-1:0]  f_rb;

    // queue
    logic [Q_W-1:0]    q_in;
    logic [Q_W-1:0]    q_out;
    logic              q_can_push;
    logic              q_not_empty;
    logic [1:0]        q_level;
    logic              q_pop;

    // back end
    op_ctrl_t          b_ctrl;
    logic [IDX_W-1:0]  b_ra;
    logic [IDX_W-1:0]  b_rb;
    logic [DATA_W-1:0] b_imm;
    result_t           b_res;
    logic              b_stopped;

    tce_front #(
        .NUM_REGS (NUM_REGS),
        .IDX_W    (IDX_W)
    ) u_front (
        .opcode      (s_axis_tdata[3:0]),
        .dest_reg    (s_axis_tdata[5:4]),
        .src_reg     (s_axis_tdata[7:6]),
        .branch_cond (s_axis_tdata[17:16]),
        .ctrl        (f_ctrl),
        .ra          (f_ra),
        .rb          (f_rb)
    );

    // classified instruction packed for the queue
    assign q_in = {f_ctrl, f_ra, f_rb, s_axis_tdata[15:8]};
    assign s_axis_tready = q_can_push;

    tce_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_data (q_in),
        .can_push  (q_can_push),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out),
        .level     (q_level)
    );

    assign {b_ctrl, b_ra, b_rb, b_imm} = q_out;

    tce_back #(
        .NUM_REGS (NUM_REGS),
        .IDX_W    (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_not_empty),
        .in_ready  (q_pop),
        .in_ctrl   (b_ctrl),
        .in_ra     (b_ra),
        .in_rb     (b_rb),
        .in_imm    (b_imm),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (b_res),
        .stopped   (b_stopped)
    );

    assign m_axis_tdata = {2'b00, b_res.halted, b_res.dest_value, b_res.taken,
                           b_res.pc_value, b_res.flags, b_res.acc_value};

    // an input transfer never lands on a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (q_level < 2'd2))
        else $error("input transfer accepted into a full queue");

    // once stopped, the machine stays stopped until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        b_stopped |=> b_stopped)
        else $error("stop flag cleared without reset");

    // a taken jump or branch loads the same target into pc and accumulator
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[20]) |-> (m_axis_tdata[19:12] == m_axis_tdata[7:0]))
        else $error("taken branch with pc and accumulator disagreeing");

    // a reported halt always matches the live stop flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[29]) |-> b_stopped)
        else $error("halted result while the unit is not stopped");

endmodule

`default_nettype wire
